[rtl/core/i2c_master_byte_engine_macros.svh]
// Assertion macros for the I2C master byte engine.
// Used by i2c_master_byte_engine.sv; expects clk_i and rst_ni in scope.
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/i2cm_pkg.sv]
// Shared types and constants of the I2C master byte engine.
// No dependencies; used by i2c_master_byte_engine.
`default_nettype none

package i2cm_pkg;

  // sequencer phases
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_RS_SDA_HIGH = 4'd1;
  localparam logic [3:0] PH_RS_WAIT     = 4'd2;
  localparam logic [3:0] PH_RS_HIGH     = 4'd3;
  localparam logic [3:0] PH_ST_SDA_LOW  = 4'd4;
  localparam logic [3:0] PH_ST_SCL_LOW  = 4'd5;
  localparam logic [3:0] PH_BIT_SETUP   = 4'd6;
  localparam logic [3:0] PH_BIT_WAIT    = 4'd7;
  localparam logic [3:0] PH_BIT_HIGH    = 4'd8;
  localparam logic [3:0] PH_BIT_LOW     = 4'd9;
  localparam logic [3:0] PH_SP_SDA_LOW  = 4'd10;
  localparam logic [3:0] PH_SP_WAIT     = 4'd11;
  localparam logic [3:0] PH_SP_HIGH     = 4'd12;
  localparam logic [3:0] PH_SP_END      = 4'd13;

  // commands
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_ADDR  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NACK    = 2'd2;

  // register map (word index)
  localparam logic REG_STRETCH = 1'b0;
  localparam logic REG_PHASE   = 1'b1;

  localparam logic [15:0] STRETCH_RESET = 16'd4000;
  localparam logic [7:0]  PHASE_RESET   = 8'd1;

  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
  localparam logic [3:0]  LAST_BIT      = 4'd9;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [1:0] status;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/i2c_master_byte_engine.sv]
// I2C master byte engine: sequencer, APB register port, output register with skid.
// Depends on i2cm_pkg and i2c_master_byte_engine_macros.svh.
//
// Each input beat is one timing tick carrying the sampled SCL/SDA levels and a
// command, which is taken only while the previous result showed ready_res. The
// sequencer advances at most one phase per tick. One result beat comes out per
// input beat and is registered; the block takes one beat every cycle while
// in_stall_o is low. An output register plus a one-entry skid stage decouple
// the two sides, so in_stall_o rises only once two results are waiting.
// Registers: stretch_timeout at 0x0, phase_ticks at 0x4; a value of 0 acts as 1.
`default_nettype none
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tick channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        read_not_write_i,
  input  wire logic        send_ack_i,
  input  wire logic        scl_level_i,
  input  wire logic        sda_level_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scl_pull_low_o,
  output logic             sda_pull_low_o,
  output logic             ready_res_o,
  output logic             done_res_o,
  output logic [7:0]       rx_byte_o,
  output logic [1:0]       status_o,
  // APB register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- configuration ----------------
  logic [15:0] stretch_timeout_q;
  logic [7:0]  phase_ticks_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stretch_timeout_q <= i2cm_pkg::STRETCH_RESET;
      phase_ticks_q     <= i2cm_pkg::PHASE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == i2cm_pkg::REG_STRETCH) begin
        stretch_timeout_q <= pwdata[15:0];
      end else begin
        phase_ticks_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == i2cm_pkg::REG_PHASE) begin
      prdata = {24'd0, phase_ticks_q};
    end else begin
      prdata = {16'd0, stretch_timeout_q};
    end
  end

  // ---------------- sequencer state ----------------
  logic [3:0]  phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] wait_q, wait_d;
  logic [7:0]  tick_q, tick_d;
  logic        scl_drv_q, scl_drv_d;
  logic        sda_drv_q, sda_drv_d;
  logic [1:0]  status_q, status_d;
  logic        ack_q, ack_d;
  logic [7:0]  rx_q, rx_d;
  logic        done_d;

  logic [7:0]  tick_lim, tick_inc;
  logic [15:0] wait_lim, wait_inc;
  logic        hold_over, wait_to;
  logic [3:0]  bit_next;

  logic        in_acc;

  // SDA drive at the start of a bit slot: data bits for writes, ACK slot for reads
  function automatic logic bit_low(input logic [2:0] cmd, input logic [3:0] bcnt,
                                   input logic [7:0] shr, input logic ack);
    logic r;
    if (cmd == i2cm_pkg::OP_READ) begin
      r = (bcnt >= i2cm_pkg::BITS_PER_BYTE) && ack;
    end else begin
      r = (bcnt < i2cm_pkg::BITS_PER_BYTE) && !shr[7];
    end
    return r;
  endfunction

  assign tick_lim  = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
  assign tick_inc  = (tick_q != 8'hff) ? tick_q + 8'd1 : tick_q;
  assign hold_over = tick_inc >= tick_lim;
  assign wait_lim  = (stretch_timeout_q == 16'd0) ? 16'd1 : stretch_timeout_q;
  assign wait_inc  = (wait_q != 16'hffff) ? wait_q + 16'd1 : wait_q;
  assign wait_to   = wait_inc >= wait_lim;
  assign bit_next  = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    wait_d    = wait_q;
    tick_d    = tick_q;
    scl_drv_d = scl_drv_q;
    sda_drv_d = sda_drv_q;
    status_d  = status_q;
    ack_d     = ack_q;
    rx_d      = rx_q;
    done_d    = 1'b0;

    unique case (phase_q)
      i2cm_pkg::PH_IDLE: begin
        unique case (opcode_i)
          i2cm_pkg::OP_START, i2cm_pkg::OP_ADDR: begin
            cmd_d     = opcode_i;
            shift_d   = {data_byte_i[6:0], read_not_write_i};
            bit_cnt_d = 4'd0;
            tick_d    = 8'd0;
            if (scl_drv_q) begin
              // SCL held low: repeated start
              sda_drv_d = 1'b0;
              phase_d   = i2cm_pkg::PH_RS_SDA_HIGH;
            end else begin
              sda_drv_d = 1'b1;
              phase_d   = i2cm_pkg::PH_ST_SDA_LOW;
            end
          end
          i2cm_pkg::OP_STOP: begin
            cmd_d     = opcode_i;
            sda_drv_d = 1'b1;
            tick_d    = 8'd0;
            phase_d   = i2cm_pkg::PH_SP_SDA_LOW;
          end
          i2cm_pkg::OP_WRITE: begin
            cmd_d     = opcode_i;
            shift_d   = data_byte_i;
            bit_cnt_d = 4'd0;
            sda_drv_d = !data_byte_i[7];
            tick_d    = 8'd0;
            phase_d   = i2cm_pkg::PH_BIT_SETUP;
          end
          i2cm_pkg::OP_READ: begin
            cmd_d     = opcode_i;
            shift_d   = 8'd0;
            ack_d     = send_ack_i;
            bit_cnt_d = 4'd0;
            sda_drv_d = 1'b0;
            tick_d    = 8'd0;
            phase_d   = i2cm_pkg::PH_BIT_SETUP;
          end
          default: begin
          end
        endcase
      end

      i2cm_pkg::PH_RS_SDA_HIGH: begin
        tick_d = tick_inc;
        if (hold_over) begin
          scl_drv_d = 1'b0;
          wait_d    = 16'd0;
          phase_d   = i2cm_pkg::PH_RS_WAIT;
        end
      end

      i2cm_pkg::PH_RS_WAIT: begin
        if (scl_level_i) begin
          tick_d  = 8'd0;
          phase_d = i2cm_pkg::PH_RS_HIGH;
        end else begin
          wait_d = wait_inc;
          if (wait_to) begin
            status_d = i2cm_pkg::ST_TIMEOUT;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end
        end
      end

      i2cm_pkg::PH_RS_HIGH: begin
        tick_d = tick_inc;
        if (hold_over) begin
          sda_drv_d = 1'b1;
          tick_d    = 8'd0;
          phase_d   = i2cm_pkg::PH_ST_SDA_LOW;
        end
      end

      i2cm_pkg::PH_ST_SDA_LOW: begin
        tick_d = tick_inc;
        if (hold_over) begin
          scl_drv_d = 1'b1;
          tick_d    = 8'd0;
          phase_d   = i2cm_pkg::PH_ST_SCL_LOW;
        end
      end

      i2cm_pkg::PH_ST_SCL_LOW: begin
        tick_d = tick_inc;
        if (hold_over) begin
          if (cmd_q == i2cm_pkg::OP_ADDR) begin
            bit_cnt_d = 4'd0;
            sda_drv_d = bit_low(cmd_q, 4'd0, shift_q, ack_q);
            tick_d    = 8'd0;
            phase_d   = i2cm_pkg::PH_BIT_SETUP;
          end else begin
            status_d = i2cm_pkg::ST_OK;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end
        end
      end

      i2cm_pkg::PH_BIT_SETUP: begin
        tick_d = tick_inc;
        if (hold_over) begin
          scl_drv_d = 1'b0;
          wait_d    = 16'd0;
          phase_d   = i2cm_pkg::PH_BIT_WAIT;
        end
      end

      i2cm_pkg::PH_BIT_WAIT: begin
        if (scl_level_i) begin
          // sample SDA on the first tick SCL reads high
          if (bit_cnt_q < i2cm_pkg::BITS_PER_BYTE) begin
            shift_d = {shift_q[6:0], (cmd_q == i2cm_pkg::OP_READ) && sda_level_i};
          end else if (cmd_q != i2cm_pkg::OP_READ) begin
            ack_d = sda_level_i;
          end
          tick_d  = 8'd0;
          phase_d = i2cm_pkg::PH_BIT_HIGH;
        end else begin
          wait_d = wait_inc;
          if (wait_to) begin
            status_d = i2cm_pkg::ST_TIMEOUT;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end
        end
      end

      i2cm_pkg::PH_BIT_HIGH: begin
        tick_d = tick_inc;
        if (hold_over) begin
          scl_drv_d = 1'b1;
          tick_d    = 8'd0;
          phase_d   = i2cm_pkg::PH_BIT_LOW;
        end
      end

      i2cm_pkg::PH_BIT_LOW: begin
        tick_d = tick_inc;
        if (hold_over) begin
          bit_cnt_d = bit_next;
          if (bit_next < i2cm_pkg::LAST_BIT) begin
            sda_drv_d = bit_low(cmd_q, bit_next, shift_q, ack_q);
            tick_d    = 8'd0;
            phase_d   = i2cm_pkg::PH_BIT_SETUP;
          end else if (cmd_q == i2cm_pkg::OP_WRITE) begin
            status_d = ack_q ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end else if (cmd_q == i2cm_pkg::OP_READ) begin
            rx_d     = shift_q;
            status_d = i2cm_pkg::ST_OK;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end else if (ack_q) begin
            // address not acknowledged: automatic stop
            status_d  = i2cm_pkg::ST_NACK;
            sda_drv_d = 1'b1;
            tick_d    = 8'd0;
            phase_d   = i2cm_pkg::PH_SP_SDA_LOW;
          end else begin
            status_d = i2cm_pkg::ST_OK;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end
        end
      end

      i2cm_pkg::PH_SP_SDA_LOW: begin
        tick_d = tick_inc;
        if (hold_over) begin
          scl_drv_d = 1'b0;
          wait_d    = 16'd0;
          phase_d   = i2cm_pkg::PH_SP_WAIT;
        end
      end

      i2cm_pkg::PH_SP_WAIT: begin
        if (scl_level_i) begin
          tick_d  = 8'd0;
          phase_d = i2cm_pkg::PH_SP_HIGH;
        end else begin
          wait_d = wait_inc;
          if (wait_to) begin
            status_d = (cmd_q == i2cm_pkg::OP_ADDR) ? i2cm_pkg::ST_NACK
                                                    : i2cm_pkg::ST_TIMEOUT;
            phase_d  = i2cm_pkg::PH_IDLE;
            done_d   = 1'b1;
          end
        end
      end

      i2cm_pkg::PH_SP_HIGH: begin
        tick_d = tick_inc;
        if (hold_over) begin
          sda_drv_d = 1'b0;
          tick_d    = 8'd0;
          phase_d   = i2cm_pkg::PH_SP_END;
        end
      end

      i2cm_pkg::PH_SP_END: begin
        tick_d = tick_inc;
        if (hold_over) begin
          status_d = (cmd_q == i2cm_pkg::OP_ADDR) ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
          phase_d  = i2cm_pkg::PH_IDLE;
          done_d   = 1'b1;
        end
      end

      default: begin
        phase_d = i2cm_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2cm_pkg::PH_IDLE;
      cmd_q     <= i2cm_pkg::OP_NONE;
      bit_cnt_q <= 4'd0;
      shift_q   <= 8'd0;
      wait_q    <= 16'd0;
      tick_q    <= 8'd0;
      scl_drv_q <= 1'b0;
      sda_drv_q <= 1'b0;
      status_q  <= i2cm_pkg::ST_OK;
      ack_q     <= 1'b0;
      rx_q      <= 8'd0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      cmd_q     <= cmd_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
      wait_q    <= wait_d;
      tick_q    <= tick_d;
      scl_drv_q <= scl_drv_d;
      sda_drv_q <= sda_drv_d;
      status_q  <= status_d;
      ack_q     <= ack_d;
      rx_q      <= rx_d;
    end
  end

  // ---------------- result register and skid stage ----------------
  i2cm_pkg::res_t res_new, out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           out_take;

  assign res_new = '{scl_pull_low: scl_drv_d,
                     sda_pull_low: sda_drv_d,
                     ready_res:    (phase_d == i2cm_pkg::PH_IDLE),
                     done_res:     done_d,
                     rx_byte:      rx_d,
                     status:       status_d};

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc;
        end
      end else if (!out_valid_q) begin
        out_valid_q <= in_acc;
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end else if (in_acc && (out_take || !out_valid_q)) begin
      out_q <= res_new;
    end
    if (in_acc && out_valid_q && !out_take) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_pull_low_o = out_q.scl_pull_low;
  assign sda_pull_low_o = out_q.sda_pull_low;
  assign ready_res_o    = out_q.ready_res;
  assign done_res_o     = out_q.done_res;
  assign rx_byte_o      = out_q.rx_byte;
  assign status_o       = out_q.status;

  // ---------------- assertions ----------------
  `I2CM_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q,
                   "skid stage holds a beat while output register is empty")
  `I2CM_ASSERT_NOW(a_phase_known, 1'b1, phase_q <= i2cm_pkg::PH_SP_END,
                   "sequencer phase out of range")
  `I2CM_ASSERT_NOW(a_done_is_idle, out_valid_q && out_q.done_res, out_q.ready_res,
                   "done result without idle sequencer")
  `I2CM_ASSERT_NOW(a_bit_cnt_range, 1'b1, bit_cnt_q <= i2cm_pkg::LAST_BIT,
                   "bit counter past ACK slot")
  `I2CM_ASSERT_NEXT(a_stall_no_advance, in_valid_i && skid_valid_q,
                    $stable(phase_q) && $stable(tick_q),
                    "sequencer advanced on a stalled beat")

endmodule

`default_nettype wire
